// ===== src/bsl_pkg.sv =====
// Shared types, codes and pattern functions for the battery status LED sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bsl_pkg;

    localparam int unsigned MV_WIDTH = 13;
    localparam int unsigned MS_WIDTH = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 3;

    localparam logic [2:0] CLS_UNKNOWN = 3'd0;
    localparam logic [2:0] CLS_LOW = 3'd1;
    localparam logic [2:0] CLS_CHARGING = 3'd2;
    localparam logic [2:0] CLS_CHARGED = 3'd3;
    localparam logic [2:0] CLS_GOOD = 3'd4;

    localparam logic [3:0] LED_OFF = 4'h0;
    localparam logic [3:0] LED_RED = 4'h1;
    localparam logic [3:0] LED_YELLOW = 4'h2;
    localparam logic [3:0] LED_GREEN = 4'h4;
    localparam logic [3:0] LED_BLUE = 4'h8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GOOD_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHARGED_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EVAL_INTERVAL = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_HALF_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHARGE_HALF_PERIOD = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GOOD_ON = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GOOD_OFF = 3'd7;

    typedef struct packed {
        logic [MV_WIDTH-1:0] vbat_mv;
        logic                charge_pin;
        logic                good_pin;
    } in_item_t;

    typedef struct packed {
        logic [3:0] led_mask;
        logic [2:0] battery_class;
    } out_item_t;

    typedef struct packed {
        logic [MV_WIDTH-1:0] low_threshold_mv;
        logic [MV_WIDTH-1:0] good_threshold_mv;
        logic [MV_WIDTH-1:0] charged_threshold_mv;
        logic [MS_WIDTH-1:0] eval_interval_ms;
        logic [MS_WIDTH-1:0] low_half_period_ms;
        logic [MS_WIDTH-1:0] charge_half_period_ms;
        logic [MS_WIDTH-1:0] blue_on_ms;
        logic [MS_WIDTH-1:0] blue_dark_ms;
    } cfg_t;

    function automatic logic [2:0] classify(input in_item_t item, input cfg_t cfg);
        logic [2:0] cls;
        if (item.vbat_mv <= cfg.low_threshold_mv) begin
            cls = CLS_LOW;
        end else if (!item.charge_pin) begin
            cls = CLS_CHARGING;
        end else if (item.good_pin && item.vbat_mv >= cfg.charged_threshold_mv) begin
            cls = CLS_CHARGED;
        end else if (item.vbat_mv >= cfg.good_threshold_mv) begin
            cls = CLS_GOOD;
        end else if (item.good_pin) begin
            cls = CLS_CHARGED;
        end else begin
            cls = CLS_GOOD;
        end
        return cls;
    endfunction

    function automatic logic [3:0] step_mask(input logic [2:0] cls, input logic idx);
        logic [3:0] mask;
        unique case (cls)
            CLS_LOW: mask = idx ? LED_OFF : LED_RED;
            CLS_CHARGING: mask = idx ? LED_OFF : LED_YELLOW;
            CLS_CHARGED: mask = LED_GREEN;
            CLS_GOOD: mask = idx ? LED_OFF : LED_BLUE;
            default: mask = LED_OFF;
        endcase
        return mask;
    endfunction

    function automatic logic [MS_WIDTH-1:0] step_duration(input logic [2:0] cls,
                                                          input logic idx,
                                                          input cfg_t cfg);
        logic [MS_WIDTH-1:0] dur;
        unique case (cls)
            CLS_LOW: dur = cfg.low_half_period_ms;
            CLS_CHARGING: dur = cfg.charge_half_period_ms;
            CLS_GOOD: dur = idx ? cfg.blue_dark_ms : cfg.blue_on_ms;
            default: dur = '0;
        endcase
        return dur;
    endfunction

endpackage

`default_nettype wire

// ===== src/battery_status_led_sequencer.sv =====
// Top level of the battery status LED sequencer: input register, core, result register.
// Depends on bsl_pkg, bsl_cfg_regs and bsl_core.
//
// Usage:
// Each request on the input channel (in_valid, in_stall, in_data) is one
// millisecond tick with a voltage sample and the charger and good pins.
// Every tick produces exactly one result request on the output channel
// (out_valid, out_stall, out_data) with the LED mask and battery class.
// A tick is taken when in_valid is high and in_stall is low.
// A tick accepted into the input register passes through the core, and its
// result is registered in the result register as the core state updates.
// Throughput is one tick per cycle while out_stall is low; the core updates
// its state once for each tick.
// When the receiver holds out_stall, the result register holds its value;
// one more tick may wait in the input register, after which in_stall rises.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
// always accepted, as cfg_ready is tied high, and belong only in idle periods.
// Reset clears the pipeline and the pattern state and loads the default
// thresholds and timings; no clearing pass is needed.
`default_nettype none

module battery_status_led_sequencer #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire bsl_pkg::in_item_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output bsl_pkg::out_item_t                       out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bsl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [bsl_pkg::MS_WIDTH-1:0]        cfg_data
);

    bsl_pkg::cfg_t      cfg;
    bsl_pkg::in_item_t  item_reg;
    bsl_pkg::out_item_t result;
    bsl_pkg::out_item_t out_reg;
    logic               item_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_take;

    assign cfg_ready = 1'b1;
    assign advance = item_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take = in_valid && !in_stall;

    bsl_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bsl_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take || advance) begin
                item_valid_reg <= in_take;
            end
            if (advance || !out_stall) begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_take) begin
            item_reg <= in_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

// ===== src/bsl_cfg_regs.sv =====
// Configuration register file of the battery status LED sequencer.
// Depends on bsl_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module bsl_cfg_regs (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   wr_en,
    input  wire logic [bsl_pkg::CFG_INDEX_WIDTH-1:0]    wr_index,
    input  wire logic [bsl_pkg::MS_WIDTH-1:0]           wr_data,
    output bsl_pkg::cfg_t                               cfg
);

    bsl_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.low_threshold_mv <= 13'd3600;
            cfg_reg.good_threshold_mv <= 13'd3950;
            cfg_reg.charged_threshold_mv <= 13'd4100;
            cfg_reg.eval_interval_ms <= 16'd200;
            cfg_reg.low_half_period_ms <= 16'd1500;
            cfg_reg.charge_half_period_ms <= 16'd500;
            cfg_reg.blue_on_ms <= 16'd1000;
            cfg_reg.blue_dark_ms <= 16'd3000;
        end else if (wr_en) begin
            unique case (wr_index)
                bsl_pkg::REG_LOW_THRESHOLD:
                    cfg_reg.low_threshold_mv <= wr_data[bsl_pkg::MV_WIDTH-1:0];
                bsl_pkg::REG_GOOD_THRESHOLD:
                    cfg_reg.good_threshold_mv <= wr_data[bsl_pkg::MV_WIDTH-1:0];
                bsl_pkg::REG_CHARGED_THRESHOLD:
                    cfg_reg.charged_threshold_mv <= wr_data[bsl_pkg::MV_WIDTH-1:0];
                bsl_pkg::REG_EVAL_INTERVAL: cfg_reg.eval_interval_ms <= wr_data;
                bsl_pkg::REG_LOW_HALF_PERIOD: cfg_reg.low_half_period_ms <= wr_data;
                bsl_pkg::REG_CHARGE_HALF_PERIOD: cfg_reg.charge_half_period_ms <= wr_data;
                bsl_pkg::REG_GOOD_ON: cfg_reg.blue_on_ms <= wr_data;
                bsl_pkg::REG_GOOD_OFF: cfg_reg.blue_dark_ms <= wr_data;
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/bsl_core.sv =====
// Per-tick status evaluation and LED pattern stepping with its state registers.
// Depends on bsl_pkg for the item and configuration types and pattern functions.
`default_nettype none

module bsl_core #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step_en,
    input  wire bsl_pkg::in_item_t item,
    input  wire bsl_pkg::cfg_t     cfg,
    output bsl_pkg::out_item_t result
);

    localparam int unsigned CMP_WIDTH =
        (TIMER_WIDTH > bsl_pkg::MS_WIDTH) ? TIMER_WIDTH : bsl_pkg::MS_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

    logic [2:0]             class_reg, class_next;
    logic [TIMER_WIDTH-1:0] eval_elapsed_reg, eval_elapsed_next;
    logic                   step_index_reg, step_index_next;
    logic [TIMER_WIDTH-1:0] step_elapsed_reg, step_elapsed_next;
    logic                   step_pending_reg, step_pending_next;
    logic [3:0]             led_reg, led_next;

    logic [2:0]             new_class;
    logic [bsl_pkg::MS_WIDTH-1:0] dur;

    assign new_class = bsl_pkg::classify(item, cfg);

    always_comb
    begin
        class_next = class_reg;
        step_index_next = step_index_reg;
        step_pending_next = step_pending_reg;
        led_next = led_reg;
        eval_elapsed_next = (eval_elapsed_reg == TIMER_MAX) ? TIMER_MAX
                                                            : eval_elapsed_reg + TIMER_ONE;
        step_elapsed_next = (step_elapsed_reg == TIMER_MAX) ? TIMER_MAX
                                                            : step_elapsed_reg + TIMER_ONE;

        if (CMP_WIDTH'(eval_elapsed_next) >= CMP_WIDTH'(cfg.eval_interval_ms)) begin
            eval_elapsed_next = '0;
            if (new_class != class_reg) begin
                class_next = new_class;
                step_index_next = 1'b0;
                step_elapsed_next = '0;
                step_pending_next = 1'b0;
                led_next = bsl_pkg::step_mask(new_class, 1'b0);
            end
        end

        dur = bsl_pkg::step_duration(class_next, step_index_next, cfg);
        if (class_next != bsl_pkg::CLS_UNKNOWN) begin
            if (step_pending_next) begin
                led_next = bsl_pkg::step_mask(class_next, step_index_next);
                step_pending_next = 1'b0;
            end
            if (dur != '0 && CMP_WIDTH'(step_elapsed_next) >= CMP_WIDTH'(dur)) begin
                step_index_next = ~step_index_next;
                step_elapsed_next = '0;
                step_pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            class_reg <= bsl_pkg::CLS_UNKNOWN;
            eval_elapsed_reg <= '0;
            step_index_reg <= 1'b0;
            step_elapsed_reg <= '0;
            step_pending_reg <= 1'b0;
            led_reg <= bsl_pkg::LED_OFF;
        end else if (step_en) begin
            class_reg <= class_next;
            eval_elapsed_reg <= eval_elapsed_next;
            step_index_reg <= step_index_next;
            step_elapsed_reg <= step_elapsed_next;
            step_pending_reg <= step_pending_next;
            led_reg <= led_next;
        end
    end

    assign result.led_mask = led_next;
    assign result.battery_class = class_next;

endmodule

`default_nettype wire

// ===== src/bsl_checker.sv =====
// Port-level checker for the battery status LED sequencer and its bind.
// Depends on bsl_pkg for the payload types and class codes.
`default_nettype none

module bsl_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire bsl_pkg::out_item_t  out_data
);

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // The input side is held back only by a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    // An accepted tick on a free output path shows a registered result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
        else $error("accepted tick produced no result");

    // The LEDs stay dark while the class is unknown.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.battery_class == bsl_pkg::CLS_UNKNOWN
            |-> out_data.led_mask == bsl_pkg::LED_OFF)
        else $error("LEDs lit with unknown class");

    // The class code never exceeds the good class.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.battery_class <= bsl_pkg::CLS_GOOD)
        else $error("battery class out of range");

endmodule

bind battery_status_led_sequencer bsl_checker u_bsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// ===== sim/battery_status_led_sequencer_tb.sv =====
// Self-checking testbench for battery_status_led_sequencer: directed and random ticks
// over several register settings, with random input gaps and output stalls.
// Depends on bsl_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module battery_status_led_sequencer_tb;
    import bsl_pkg::*;

    localparam int TIMER_WIDTH = 16;
    localparam int unsigned TIMER_MAX = (1 << TIMER_WIDTH) - 1;
    localparam int LIMIT_CYCLES = 500000;
    localparam int MV_MAX = 8191;

    class led_status_tracker;
        logic [MV_WIDTH-1:0] low_mv;
        logic [MV_WIDTH-1:0] good_mv;
        logic [MV_WIDTH-1:0] charged_mv;
        logic [MS_WIDTH-1:0] eval_ms;
        logic [MS_WIDTH-1:0] red_half_ms;
        logic [MS_WIDTH-1:0] yellow_half_ms;
        logic [MS_WIDTH-1:0] blue_on_ms;
        logic [MS_WIDTH-1:0] blue_off_ms;
        logic [2:0] cls_now;
        int unsigned eval_cnt;
        int unsigned step_cnt;
        bit blink_phase;
        bit mask_due;
        logic [3:0] leds;
        out_item_t status_due[$];
        int mismatches;

        function new();
            low_mv = 13'd3600;
            good_mv = 13'd3950;
            charged_mv = 13'd4100;
            eval_ms = 16'd200;
            red_half_ms = 16'd1500;
            yellow_half_ms = 16'd500;
            blue_on_ms = 16'd1000;
            blue_off_ms = 16'd3000;
            cls_now = CLS_UNKNOWN;
            eval_cnt = 0;
            step_cnt = 0;
            blink_phase = 1'b0;
            mask_due = 1'b0;
            leds = LED_OFF;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [MS_WIDTH-1:0] value);
            case (idx)
                REG_LOW_THRESHOLD: low_mv = value[MV_WIDTH-1:0];
                REG_GOOD_THRESHOLD: good_mv = value[MV_WIDTH-1:0];
                REG_CHARGED_THRESHOLD: charged_mv = value[MV_WIDTH-1:0];
                REG_EVAL_INTERVAL: eval_ms = value;
                REG_LOW_HALF_PERIOD: red_half_ms = value;
                REG_CHARGE_HALF_PERIOD: yellow_half_ms = value;
                REG_GOOD_ON: blue_on_ms = value;
                default: blue_off_ms = value;
            endcase
        endfunction

        function logic [2:0] grade(in_item_t t);
            if (t.vbat_mv <= low_mv)
                return CLS_LOW;
            if (t.charge_pin == 1'b0)
                return CLS_CHARGING;
            if (t.good_pin && t.vbat_mv >= charged_mv)
                return CLS_CHARGED;
            if (t.vbat_mv >= good_mv)
                return CLS_GOOD;
            if (t.good_pin)
                return CLS_CHARGED;
            return CLS_GOOD;
        endfunction

        function logic [3:0] lit_mask(logic [2:0] cls, bit dark);
            case (cls)
                CLS_LOW: return dark ? LED_OFF : LED_RED;
                CLS_CHARGING: return dark ? LED_OFF : LED_YELLOW;
                CLS_CHARGED: return LED_GREEN;
                CLS_GOOD: return dark ? LED_OFF : LED_BLUE;
                default: return LED_OFF;
            endcase
        endfunction

        function logic [MS_WIDTH-1:0] hold_ms(logic [2:0] cls, bit dark);
            case (cls)
                CLS_LOW: return red_half_ms;
                CLS_CHARGING: return yellow_half_ms;
                CLS_GOOD: return dark ? blue_off_ms : blue_on_ms;
                default: return '0;
            endcase
        endfunction

        function int unsigned bump(int unsigned t);
            return (t >= TIMER_MAX) ? TIMER_MAX : t + 1;
        endfunction

        function void take_tick(in_item_t t);
            logic [2:0] fresh;
            logic [MS_WIDTH-1:0] hold;
            out_item_t want;
            eval_cnt = bump(eval_cnt);
            step_cnt = bump(step_cnt);
            if (eval_cnt >= eval_ms)
            begin
                fresh = grade(t);
                eval_cnt = 0;
                if (fresh != cls_now)
                begin
                    cls_now = fresh;
                    blink_phase = 1'b0;
                    step_cnt = 0;
                    mask_due = 1'b0;
                    leds = lit_mask(fresh, 1'b0);
                end
            end
            if (cls_now != CLS_UNKNOWN)
            begin
                if (mask_due)
                begin
                    leds = lit_mask(cls_now, blink_phase);
                    mask_due = 1'b0;
                end
                hold = hold_ms(cls_now, blink_phase);
                if (hold != 0 && step_cnt >= hold)
                begin
                    blink_phase = ~blink_phase;
                    step_cnt = 0;
                    mask_due = 1'b1;
                end
            end
            want.led_mask = leds;
            want.battery_class = cls_now;
            status_due.push_back(want);
        endfunction

        function void check_status(out_item_t got);
            out_item_t want;
            if (status_due.size() == 0)
            begin
                $display("%0t: result with none expected, got mask %h class %0d",
                         $time, got.led_mask, got.battery_class);
                mismatches++;
                return;
            end
            want = status_due.pop_front();
            if (got.led_mask !== want.led_mask)
            begin
                $display("%0t: led_mask expected %h got %h", $time, want.led_mask, got.led_mask);
                mismatches++;
            end
            if (got.battery_class !== want.battery_class)
            begin
                $display("%0t: battery_class expected %0d got %0d",
                         $time, want.battery_class, got.battery_class);
                mismatches++;
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [MS_WIDTH-1:0] cfg_data;

    led_status_tracker tracker = new();
    int feed_calm = 0;
    int stall_calm = 0;
    int cycles = 0;

    battery_status_led_sequencer #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("battery_status_led_sequencer test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_status(out_data);
    end

    function automatic int gap_len(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 4)
        begin
            calm_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = gap_len(stall_calm);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    function automatic logic [MV_WIDTH-1:0] clamp_mv(int v);
        if (v < 0)
            return '0;
        if (v > MV_MAX)
            return MV_WIDTH'(MV_MAX);
        return v[MV_WIDTH-1:0];
    endfunction

    task automatic send_tick(input in_item_t item);
        int gap;
        gap = gap_len(feed_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_tick(item);
    endtask

    task automatic send_run(input int vbat, input bit chg, input bit good, input int count);
        in_item_t item;
        item.vbat_mv = clamp_mv(vbat);
        item.charge_pin = chg;
        item.good_pin = good;
        repeat (count) send_tick(item);
    endtask

    function automatic in_item_t pick_tick();
        in_item_t t;
        int r;
        int v;
        r = $urandom_range(99);
        case ($urandom_range(2))
            0: v = tracker.low_mv;
            1: v = tracker.good_mv;
            default: v = tracker.charged_mv;
        endcase
        v += int'($urandom_range(8)) - 4;
        if (r < 20)
            v = $urandom_range(MV_MAX);
        else if (r < 23)
            v = 0;
        else if (r < 26)
            v = MV_MAX;
        t.vbat_mv = clamp_mv(v);
        t.charge_pin = ($urandom_range(3) != 0);
        t.good_pin = 1'($urandom_range(1));
        return t;
    endfunction

    // Ticks come in runs of steady conditions so that blink steps get to advance.
    task automatic send_random(input int count);
        in_item_t base;
        in_item_t item;
        int left;
        int run;
        int r;
        left = count;
        while (left > 0)
        begin
            base = pick_tick();
            run = ($urandom_range(3) == 0) ? 1 : $urandom_range(40, 2);
            for (int k = 0; k < run && left > 0; k++)
            begin
                item = base;
                r = $urandom_range(99);
                if (r < 8)
                begin
                    item.vbat_mv = MV_WIDTH'($urandom_range(MV_MAX));
                    item.charge_pin = 1'($urandom_range(1));
                    item.good_pin = 1'($urandom_range(1));
                end
                else if (r < 25)
                    item.vbat_mv = clamp_mv(int'(base.vbat_mv) + int'($urandom_range(4)) - 2);
                send_tick(item);
                left--;
            end
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [MS_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cfg(input int unsigned lo, input int unsigned gd, input int unsigned ch,
                            input int unsigned ev, input int unsigned red,
                            input int unsigned yellow, input int unsigned blue_on,
                            input int unsigned blue_off);
        settle();
        write_reg(REG_LOW_THRESHOLD, 16'(lo));
        write_reg(REG_GOOD_THRESHOLD, 16'(gd));
        write_reg(REG_CHARGED_THRESHOLD, 16'(ch));
        write_reg(REG_EVAL_INTERVAL, 16'(ev));
        write_reg(REG_LOW_HALF_PERIOD, 16'(red));
        write_reg(REG_CHARGE_HALF_PERIOD, 16'(yellow));
        write_reg(REG_GOOD_ON, 16'(blue_on));
        write_reg(REG_GOOD_OFF, 16'(blue_off));
    endtask

    function automatic int unsigned pick_ms();
        return ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(12, 1);
    endfunction

    initial
    begin
        int unsigned lo;
        int unsigned gd;
        int unsigned ch;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default settings: the class stays unknown and dark until the first evaluation.
        send_random(220);

        load_cfg(3600, 3950, 4100, 1, 2, 2, 2, 3);
        send_run(0, 1'b1, 1'b1, 5);
        send_run(3600, 1'b0, 1'b0, 1);
        send_run(3601, 1'b0, 1'b1, 4);
        send_run(MV_MAX, 1'b0, 1'b0, 1);
        send_run(4100, 1'b1, 1'b1, 2);
        send_run(4099, 1'b1, 1'b1, 5);
        send_run(3950, 1'b1, 1'b0, 1);
        send_run(3949, 1'b1, 1'b1, 1);
        send_run(3949, 1'b1, 1'b0, 2);
        send_run(MV_MAX, 1'b1, 1'b1, 1);

        // Evaluation on every tick, and steps of zero length that never end.
        load_cfg(3600, 3950, 4100, 0, 0, 0, 0, 4);
        send_random(120);

        load_cfg(0, 0, 0, 1, 1, 1, 1, 1);
        send_random(60);

        load_cfg(MV_MAX, MV_MAX, MV_MAX, 65535, 65535, 65535, 65535, 65535);
        send_random(40);

        for (int p = 0; p < 5; p++)
        begin
            lo = $urandom_range(3800, 3000);
            gd = lo + $urandom_range(500);
            ch = gd + $urandom_range(400);
            if (p == 2)
                lo = MV_MAX;
            load_cfg(lo, gd, ch, $urandom_range(8, 1), pick_ms(), pick_ms(), pick_ms(),
                     pick_ms());
            send_random(85);
        end

        settle();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("battery_status_led_sequencer test passed");
        else
            $display("battery_status_led_sequencer test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/bsl_pkg.sv
src/bsl_cfg_regs.sv
src/bsl_core.sv
src/battery_status_led_sequencer.sv
src/bsl_checker.sv
sim/battery_status_led_sequencer_tb.sv
